### rtl/wws_pkg.sv
package wws_pkg;

  // Width of one voltage sample, signed Q10.6.
  localparam int SAMPLE_BITS = 16;
  localparam int CLIP_COUNT_W = 13;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_SELECT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_LIMIT = 1'd1;

  localparam logic [1:0] PHASE_A = 2'd0;
  localparam logic [1:0] PHASE_B = 2'd1;

  localparam logic [15:0] CLIP_LIMIT_RESET = 16'd20794;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] phase_a_sample;
    logic signed [SAMPLE_BITS-1:0] phase_b_sample;
    logic signed [SAMPLE_BITS-1:0] phase_c_sample;
    logic last_sample;
  } sample_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] rms_voltage;
    logic [SAMPLE_BITS-1:0] peak_to_peak;
    logic signed [SAMPLE_BITS-1:0] dc_offset;
    logic [CLIP_COUNT_W-1:0] clipped_count;
  } result_t;

  // Strobes from the top-level sequencer to the accumulator datapath.
  typedef struct packed {
    logic capture;
    logic square;
    logic accumulate;
    logic clear;
  } acc_ctrl_t;

endpackage

### rtl/wws_accum.sv
module wws_accum #(
  parameter int MAX_WINDOW = 4096,
  parameter int TALLY_W = 13,
  parameter int SQ_W = 43,
  parameter int SUM_W = 29
) (
  input  logic clk,
  input  logic rst,
  input  wws_pkg::acc_ctrl_t ctrl,
  input  logic signed [wws_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [wws_pkg::CFG_DATA_W-1:0] clip_limit,
  output logic [SQ_W-1:0] square_sum,
  output logic signed [SUM_W-1:0] value_sum,
  output logic signed [wws_pkg::SAMPLE_BITS-1:0] window_max,
  output logic signed [wws_pkg::SAMPLE_BITS-1:0] window_min,
  output logic [TALLY_W-1:0] clip_tally,
  output logic [TALLY_W-1:0] sample_tally
);
  import wws_pkg::*;

  logic signed [SAMPLE_BITS-1:0] value;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS-1:0] sample_mag;
  logic [2*SAMPLE_BITS-1:0] square;
  logic clip_hit;

  // Magnitude of the most negative code wraps to its unsigned value, which is right.
  assign sample_mag = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      value <= sample;
      mag <= sample_mag;
    end
    if (ctrl.square) begin
      square <= mag * mag;
      clip_hit <= ({{(CFG_DATA_W){1'b0}}, mag} >= {{(SAMPLE_BITS){1'b0}}, clip_limit});
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      square_sum <= '0;
      value_sum <= '0;
      window_max <= '0;
      window_min <= '0;
      clip_tally <= '0;
      sample_tally <= '0;
    end else if (ctrl.accumulate && (sample_tally < TALLY_W'(MAX_WINDOW))) begin
      if (sample_tally == '0) begin
        window_max <= value;
        window_min <= value;
      end else begin
        if (value > window_max) begin
          window_max <= value;
        end
        if (value < window_min) begin
          window_min <= value;
        end
      end
      square_sum <= square_sum + SQ_W'(square);
      value_sum <= value_sum + SUM_W'(value);
      clip_tally <= clip_tally + TALLY_W'(clip_hit);
      sample_tally <= sample_tally + TALLY_W'(1);
    end
  end

endmodule

### rtl/wws_math.sv
module wws_math #(
  parameter int TALLY_W = 13,
  parameter int SQ_W = 43,
  parameter int SUM_W = 29
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [SQ_W-1:0] square_sum,
  input  logic signed [SUM_W-1:0] value_sum,
  input  logic [TALLY_W-1:0] count,
  output logic done,
  output logic [wws_pkg::SAMPLE_BITS-1:0] rms,
  output logic signed [wws_pkg::SAMPLE_BITS-1:0] dc
);
  import wws_pkg::*;

  localparam int DIV_U = TALLY_W + 1;
  localparam int SQRT_U = SAMPLE_BITS + 3;
  localparam int U = (DIV_U > SQRT_U) ? DIV_U : SQRT_U;
  localparam int CNT_W = $clog2(SQ_W);
  localparam int RAD_W = 2 * SAMPLE_BITS;

  typedef enum logic [2:0] {
    M_IDLE,
    M_DIV_SQ,
    M_SQRT,
    M_DIV_DC,
    M_DONE
  } mstate_t;

  mstate_t state;
  logic [SQ_W-1:0] dvd;
  logic [SQ_W-1:0] dvd_next;
  logic [U-1:0] rem;
  logic [U-1:0] rem_next;
  logic [TALLY_W-1:0] divisor;
  logic [RAD_W-1:0] radicand;
  logic [SAMPLE_BITS-1:0] root;
  logic signed [SUM_W-1:0] vsum;
  logic [SUM_W-1:0] vsum_mag;
  logic [SAMPLE_BITS-1:0] quot;
  logic neg;
  logic [CNT_W-1:0] cnt;

  logic [U-1:0] op_a;
  logic [U-1:0] op_b;
  logic [U:0] diff;
  logic ge;

  assign vsum_mag = vsum[SUM_W-1] ? SUM_W'(-vsum) : SUM_W'(vsum);

  // The one shared subtractor: a restoring division step or a square-root digit step.
  always_comb begin
    case (state)
      M_DIV_SQ, M_DIV_DC: begin
        op_a = U'({rem[TALLY_W-1:0], dvd[SQ_W-1]});
        op_b = U'(divisor);
      end
      M_SQRT: begin
        op_a = {rem[U-3:0], radicand[RAD_W-1 -: 2]};
        op_b = U'({root, 2'b01});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge = !diff[U];
    rem_next = ge ? diff[U-1:0] : op_a;
    dvd_next = {dvd[SQ_W-2:0], ge};
    quot = SAMPLE_BITS'(dvd_next);
  end

  assign done = (state == M_DONE);
  assign rms = root;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
    end else begin
      case (state)
        M_IDLE: begin
          if (start) begin
            dvd <= square_sum;
            divisor <= count;
            vsum <= value_sum;
            rem <= '0;
            cnt <= '0;
            state <= M_DIV_SQ;
          end
        end
        M_DIV_SQ: begin
          dvd <= dvd_next;
          if (cnt == CNT_W'(SQ_W - 1)) begin
            radicand <= RAD_W'(dvd_next);
            root <= '0;
            rem <= '0;
            cnt <= '0;
            state <= M_SQRT;
          end else begin
            rem <= rem_next;
            cnt <= cnt + CNT_W'(1);
          end
        end
        M_SQRT: begin
          radicand <= radicand << 2;
          root <= {root[SAMPLE_BITS-2:0], ge};
          if (cnt == CNT_W'(SAMPLE_BITS - 1)) begin
            dvd <= SQ_W'(vsum_mag);
            neg <= vsum[SUM_W-1];
            rem <= '0;
            cnt <= '0;
            state <= M_DIV_DC;
          end else begin
            rem <= rem_next;
            cnt <= cnt + CNT_W'(1);
          end
        end
        M_DIV_DC: begin
          dvd <= dvd_next;
          rem <= rem_next;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(SQ_W - 1)) begin
            dc <= neg ? -quot : quot;
            state <= M_DONE;
          end
        end
        M_DONE: begin
          state <= M_IDLE;
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/waveform_window_statistics_core.sv
// A sample that does not close its window goes through the capture, square and accumulate steps,
// and the block takes no new request until it is through with the last one.
// A closing sample then runs the back end before its result reaches the
// result register: two SQ_W-step divisions and a 16-step square root on one subtractor.
// The result register lets the next window start while a result waits to be taken.
// Synchronous active-high reset clears all accumulators and loads the register defaults.
module waveform_window_statistics_core #(
  parameter int MAX_WINDOW = 4096
) (
  input  logic clk,
  input  logic rst,
  input  logic sample_valid,
  output logic sample_stall,
  input  wws_pkg::sample_t sample_data,
  output logic result_valid,
  input  logic result_stall,
  output wws_pkg::result_t result_data,
  input  logic cfg_write,
  input  logic [wws_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wws_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wws_pkg::*;

  // The sample counter must hold MAX_WINDOW itself; sums grow by that many bits.
  localparam int TALLY_W = $clog2(MAX_WINDOW + 1);
  localparam int SQ_W = 2 * SAMPLE_BITS - 2 + TALLY_W;
  localparam int SUM_W = SAMPLE_BITS + TALLY_W;

  typedef enum logic [2:0] {
    T_IDLE,
    T_SQUARE,
    T_ACCUM,
    T_START,
    T_MATH,
    T_LOAD
  } tstate_t;

  tstate_t state;
  logic [1:0] phase_select;
  logic [CFG_DATA_W-1:0] clip_limit;
  logic last_reg;
  logic [SAMPLE_BITS-1:0] p2p_hold;
  logic [CLIP_COUNT_W-1:0] clip_hold;

  acc_ctrl_t acc_ctrl;
  logic signed [SAMPLE_BITS-1:0] selected;
  logic accept;

  logic [SQ_W-1:0] square_sum;
  logic signed [SUM_W-1:0] value_sum;
  logic signed [SAMPLE_BITS-1:0] window_max;
  logic signed [SAMPLE_BITS-1:0] window_min;
  logic [TALLY_W-1:0] clip_tally;
  logic [TALLY_W-1:0] sample_tally;

  logic math_done;
  logic [SAMPLE_BITS-1:0] math_rms;
  logic signed [SAMPLE_BITS-1:0] math_dc;
  logic out_free;

  // Configuration registers. The unused selector code falls through to phase C.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_select <= PHASE_A;
      clip_limit <= CLIP_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PHASE_SELECT: phase_select <= cfg_data[1:0];
        REG_CLIP_LIMIT: clip_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (phase_select)
      PHASE_A: selected = sample_data.phase_a_sample;
      PHASE_B: selected = sample_data.phase_b_sample;
      default: selected = sample_data.phase_c_sample;
    endcase
  end

  // The sequencer takes a new request only when it has nothing in flight.
  assign sample_stall = (state != T_IDLE);
  assign accept = sample_valid && !sample_stall;
  assign out_free = !result_valid || !result_stall;

  assign acc_ctrl.capture = accept;
  assign acc_ctrl.square = (state == T_SQUARE);
  assign acc_ctrl.accumulate = (state == T_ACCUM);
  // The math unit snapshots the sums on the same edge that clears them.
  assign acc_ctrl.clear = (state == T_START);

  wws_accum #(
    .MAX_WINDOW(MAX_WINDOW),
    .TALLY_W(TALLY_W),
    .SQ_W(SQ_W),
    .SUM_W(SUM_W)
  ) u_accum (
    .clk(clk),
    .rst(rst),
    .ctrl(acc_ctrl),
    .sample(selected),
    .clip_limit(clip_limit),
    .square_sum(square_sum),
    .value_sum(value_sum),
    .window_max(window_max),
    .window_min(window_min),
    .clip_tally(clip_tally),
    .sample_tally(sample_tally)
  );

  wws_math #(
    .TALLY_W(TALLY_W),
    .SQ_W(SQ_W),
    .SUM_W(SUM_W)
  ) u_math (
    .clk(clk),
    .rst(rst),
    .start(state == T_START),
    .square_sum(square_sum),
    .value_sum(value_sum),
    .count(sample_tally),
    .done(math_done),
    .rms(math_rms),
    .dc(math_dc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      result_valid <= 1'b0;
    end else begin
      // A taken result empties the register unless the load step refills it.
      if (result_valid && !result_stall && (state != T_LOAD)) begin
        result_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (accept) begin
            last_reg <= sample_data.last_sample;
            state <= T_SQUARE;
          end
        end
        T_SQUARE: state <= T_ACCUM;
        T_ACCUM: state <= last_reg ? T_START : T_IDLE;
        T_START: begin
          // Peak-to-peak keeps only the low bits of the difference.
          p2p_hold <= SAMPLE_BITS'(window_max - window_min);
          clip_hold <= CLIP_COUNT_W'(clip_tally);
          state <= T_MATH;
        end
        T_MATH: begin
          if (math_done) begin
            state <= T_LOAD;
          end
        end
        T_LOAD: begin
          // Hold the result until the output register is empty or being emptied.
          if (out_free) begin
            result_data.rms_voltage <= math_rms;
            result_data.peak_to_peak <= p2p_hold;
            result_data.dc_offset <= math_dc;
            result_data.clipped_count <= clip_hold;
            result_valid <= 1'b1;
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // A result only ever appears from the load step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == T_LOAD)
    else $error("result appeared outside the load step");

  // The math unit finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    math_done |-> state == T_MATH)
    else $error("math unit finished while not awaited");

  // A closing sample always leads into the back-end computation.
  assert property (@(posedge clk) disable iff (rst)
    (state == T_ACCUM && last_reg) |=> state == T_START)
    else $error("closing sample did not start the back end");

  // The sample counter never passes the window limit.
  assert property (@(posedge clk) disable iff (rst)
    sample_tally <= TALLY_W'(MAX_WINDOW))
    else $error("sample count beyond window limit");

endmodule
